FILE: hdl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg: shared types and constants of the ray set collator
// Holds the operation and status codes, the sequencer states, the default
// sizes and the control and status structs of the free handle queue.
// ----------------------------------------------------------------------------
package rsc_pkg;

  // default sizes
  localparam int unsigned DefMaxSets  = 8;
  localparam int unsigned DefMaxPrt   = 4;
  localparam int unsigned Channels    = 4;
  localparam int unsigned DefFreeDepth = 64;
  localparam int unsigned HandleW     = 16;
  localparam int unsigned KeyW        = 32;
  localparam int unsigned DiscardW    = 16;

  // operation codes
  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_POP_SET  = 2'd1;
  localparam logic [1:0] OP_POP_FREE = 2'd2;
  localparam logic [1:0] OP_READ_CLR = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_RADAR = 3'd1;
  localparam logic [2:0] ST_BAD   = 3'd2;
  localparam logic [2:0] ST_DUP   = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;
  localparam logic [2:0] ST_EMPTY = 3'd5;

  // configuration register indexes
  localparam logic CFG_RADAR_ID = 1'b0;
  localparam logic CFG_PRT_CNT  = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MATCH,
    S_DECIDE,
    S_PLACE,
    S_MIN,
    S_MIN_CHK,
    S_REL_RD,
    S_REL_WR,
    S_POP_RD,
    S_POP_OUT,
    S_FREE_OUT
  } state_e;

  // free queue control and status
  typedef struct packed {
    logic push;
    logic pop;
    logic clear_ovf;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic overflow;
  } fifo_stat_t;

endpackage

FILE: hdl/rsc_free_fifo.sv
// ----------------------------------------------------------------------------
// rsc_free_fifo: queue of released ray handles
// Circular buffer in a memory with a sticky overflow flag; a push into a full
// queue drops the handle. The head is read into a register on pop.
// ----------------------------------------------------------------------------
module rsc_free_fifo #(
  parameter int unsigned Depth = rsc_pkg::DefFreeDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rsc_pkg::fifo_ctrl_t         ctrl_i,
  input  logic [rsc_pkg::HandleW-1:0] push_data_i,
  output logic [rsc_pkg::HandleW-1:0] pop_data_o,
  output rsc_pkg::fifo_stat_t         stat_o
);
  import rsc_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned OccW = $clog2(Depth + 1);

  logic [HandleW-1:0] mem [Depth];
  logic [PtrW-1:0]    rptr_q, rptr_d, wptr_q, wptr_d;
  logic [OccW-1:0]    occ_q, occ_d;
  logic               ovf_q, ovf_d;
  logic [HandleW-1:0] rd_q;
  logic               full;

  assign full = (occ_q == OccW'(Depth));

  // pointer, count and flag update
  always_comb begin
    rptr_d = rptr_q;
    wptr_d = wptr_q;
    occ_d  = occ_q;
    ovf_d  = ovf_q;
    if (ctrl_i.push) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
        occ_d  = occ_q + 1'b1;
      end
    end else if (ctrl_i.pop && occ_q != '0) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      occ_d  = occ_q - 1'b1;
    end
    if (ctrl_i.clear_ovf) begin
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q <= '0;
      wptr_q <= '0;
      occ_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      rptr_q <= rptr_d;
      wptr_q <= wptr_d;
      occ_q  <= occ_d;
      ovf_q  <= ovf_d;
    end
  end

  // handle memory
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !full) begin
      mem[wptr_q] <= push_data_i;
    end
    if (ctrl_i.pop) begin
      rd_q <= mem[rptr_q];
    end
  end

  assign pop_data_o      = rd_q;
  assign stat_o.empty    = (occ_q == '0);
  assign stat_o.overflow = ovf_q;

endmodule

FILE: hdl/ray_set_collator.sv
// ----------------------------------------------------------------------------
// ray_set_collator: gathers radar ray handles into sets keyed by ray number
// A small sequencer steps key comparisons over the set table row by row and walks
// the slots of one set through the handle memory, one slot at a time.
// ----------------------------------------------------------------------------
// An add scans the set table for the ray number and a free set, then stores the
// handle; when a set completes, each incomplete set with a lower ray number than
// the lowest complete set is released into the free queue handle by handle.
// A set pop finds the lowest ray number and hands out that set slot by slot.
// Busy drops as the last result appears; results cannot be stalled.
// Reset clears the set table, the free queue and the discard count.
module ray_set_collator #(
  parameter int unsigned MAX_SETS   = rsc_pkg::DefMaxSets,
  parameter int unsigned MAX_PRT    = rsc_pkg::DefMaxPrt,
  parameter int unsigned FREE_DEPTH = rsc_pkg::DefFreeDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [7:0]                   cfg_wdata_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   op_i,
  input  logic [7:0]                   radar_tag_i,
  input  logic [2:0]                   channel_number_i,
  input  logic [rsc_pkg::KeyW-1:0]     ray_number_i,
  input  logic [2:0]                   prt_index_i,
  input  logic [rsc_pkg::HandleW-1:0]  ray_handle_i,
  output logic                         res_valid_o,
  output logic [2:0]                   status_o,
  output logic [rsc_pkg::HandleW-1:0]  handle_out_o,
  output logic [1:0]                   prt_out_o,
  output logic [2:0]                   channel_out_o,
  output logic [rsc_pkg::DiscardW-1:0] discard_total_o,
  output logic                         handles_lost_o,
  output logic                         last_o
);
  import rsc_pkg::*;

  localparam int unsigned Slots  = MAX_PRT * Channels;
  localparam int unsigned SlotW  = $clog2(Slots);
  localparam int unsigned SetW   = $clog2(MAX_SETS);
  localparam int unsigned FillW  = $clog2(Slots + 1);
  localparam int unsigned AddrW  = SetW + SlotW;
  localparam int unsigned NpW    = $clog2(MAX_PRT + 1);

  // configuration
  logic [7:0] own_id_q;
  logic [2:0] prt_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q  <= '0;
      prt_cnt_q <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RADAR_ID: own_id_q  <= cfg_wdata_i;
        CFG_PRT_CNT:  prt_cnt_q <= cfg_wdata_i[2:0];
        default:      own_id_q  <= own_id_q;
      endcase
    end
  end

  // effective prt count and full set size
  logic [NpW-1:0]   np;
  logic [FillW-1:0] target;

  always_comb begin
    if (prt_cnt_q == 3'd0) begin
      np = NpW'(1);
    end else if ({1'b0, prt_cnt_q} > 4'(MAX_PRT)) begin
      np = NpW'(MAX_PRT);
    end else begin
      np = NpW'(prt_cnt_q);
    end
    target = FillW'(np * Channels);
  end

  // set table
  logic                set_valid_q [MAX_SETS];
  logic [KeyW-1:0]     set_key_q   [MAX_SETS];
  logic [FillW-1:0]    set_fill_q  [MAX_SETS];
  logic [Slots-1:0]    set_mask_q  [MAX_SETS];
  logic [HandleW-1:0]  slot_mem    [MAX_SETS << SlotW];
  logic [HandleW-1:0]  mem_rd_q;

  // sequencer registers
  state_e              state_q, state_d;
  logic                pop_mode_q, pop_mode_d;
  logic [SetW-1:0]     row_q, row_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic [SlotW-1:0]    in_slot_q, in_slot_d;
  logic [KeyW-1:0]     key_q, key_d;
  logic [HandleW-1:0]  handle_q, handle_d;
  logic                hit_q, hit_d, free_q, free_d, any_q, any_d;
  logic [SetW-1:0]     hit_row_q, hit_row_d, free_row_q, free_row_d;
  logic [SetW-1:0]     best_row_q, best_row_d;
  logic [KeyW-1:0]     best_key_q, best_key_d;
  logic [DiscardW-1:0] disc_q, disc_d;

  // table and memory strobes
  logic                tab_open, tab_add, tab_release;
  logic                mem_we, mem_re;
  logic [AddrW-1:0]    mem_rd_addr;

  // result request
  logic                emit, emit_last;
  logic [2:0]          emit_status;
  logic [HandleW-1:0]  emit_handle;
  logic [1:0]          emit_prt;
  logic [2:0]          emit_chan;
  logic [DiscardW-1:0] emit_disc;

  // free queue
  fifo_ctrl_t          fifo_ctrl;
  fifo_stat_t          fifo_stat;
  logic [HandleW-1:0]  fifo_data;

  rsc_free_fifo #(
    .Depth (FREE_DEPTH)
  ) u_free_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (fifo_ctrl),
    .push_data_i (mem_rd_q),
    .pop_data_o  (fifo_data),
    .stat_o      (fifo_stat)
  );

  // current row view and helpers
  logic             row_valid;
  logic [KeyW-1:0]  row_key;
  logic [FillW-1:0] row_fill;
  logic [Slots-1:0] row_mask;
  logic             row_last, slot_last;
  logic [5:0]       slot_calc;
  logic [FillW:0]   new_fill;
  logic [DiscardW:0] disc_sum;

  assign row_valid = set_valid_q[row_q];
  assign row_key   = set_key_q[row_q];
  assign row_fill  = set_fill_q[row_q];
  assign row_mask  = set_mask_q[row_q];
  assign row_last  = (row_q == SetW'(MAX_SETS - 1));
  assign slot_last = (slot_q == SlotW'(Slots - 1));
  assign slot_calc = 6'({prt_index_i, 2'b00}) + 6'(channel_number_i) - 6'd1;
  assign new_fill  = (hit_q ? {1'b0, row_fill} : '0) + 1'b1;
  assign disc_sum  = {1'b0, disc_q} + (DiscardW + 1)'(row_fill);

  // next state and outputs
  always_comb begin
    state_d     = state_q;
    pop_mode_d  = pop_mode_q;
    row_d       = row_q;
    slot_d      = slot_q;
    in_slot_d   = in_slot_q;
    key_d       = key_q;
    handle_d    = handle_q;
    hit_d       = hit_q;
    free_d      = free_q;
    any_d       = any_q;
    hit_row_d   = hit_row_q;
    free_row_d  = free_row_q;
    best_row_d  = best_row_q;
    best_key_d  = best_key_q;
    disc_d      = disc_q;
    tab_open    = 1'b0;
    tab_add     = 1'b0;
    tab_release = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_rd_addr = {row_q, slot_q};
    fifo_ctrl   = '0;
    emit        = 1'b0;
    emit_last   = 1'b1;
    emit_status = ST_OK;
    emit_handle = '0;
    emit_prt    = '0;
    emit_chan   = '0;
    emit_disc   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (op_i)
            OP_ADD: begin
              if (radar_tag_i != own_id_q) begin
                emit        = 1'b1;
                emit_status = ST_RADAR;
              end else if (channel_number_i == 3'd0 || channel_number_i > 3'(Channels)
                           || {1'b0, prt_index_i} >= 4'(np)) begin
                emit        = 1'b1;
                emit_status = ST_BAD;
              end else begin
                key_d     = ray_number_i;
                handle_d  = ray_handle_i;
                in_slot_d = slot_calc[SlotW-1:0];
                hit_d     = 1'b0;
                free_d    = 1'b0;
                row_d     = '0;
                state_d   = S_MATCH;
              end
            end
            OP_POP_SET: begin
              pop_mode_d = 1'b1;
              any_d      = 1'b0;
              row_d      = '0;
              state_d    = S_MIN;
            end
            OP_POP_FREE: begin
              if (fifo_stat.empty) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                fifo_ctrl.pop = 1'b1;
                state_d       = S_FREE_OUT;
              end
            end
            OP_READ_CLR: begin
              emit                = 1'b1;
              emit_disc           = disc_q;
              disc_d              = '0;
              fifo_ctrl.clear_ovf = 1'b1;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      // look for the ray number and the first unused set
      S_MATCH: begin
        if (row_valid && row_key == key_q && !hit_q) begin
          hit_d     = 1'b1;
          hit_row_d = row_q;
        end
        if (!row_valid && !free_q) begin
          free_d     = 1'b1;
          free_row_d = row_q;
        end
        if (row_last) begin
          state_d = S_DECIDE;
        end else begin
          row_d = row_q + 1'b1;
        end
      end

      S_DECIDE: begin
        if (hit_q) begin
          row_d   = hit_row_q;
          state_d = S_PLACE;
        end else if (free_q) begin
          row_d   = free_row_q;
          state_d = S_PLACE;
        end else begin
          emit        = 1'b1;
          emit_status = ST_FULL;
          state_d     = S_IDLE;
        end
      end

      // store the handle, trigger the flush when the set completes
      S_PLACE: begin
        if (hit_q && row_mask[in_slot_q]) begin
          emit        = 1'b1;
          emit_status = ST_DUP;
          state_d     = S_IDLE;
        end else begin
          tab_open = !hit_q;
          tab_add  = 1'b1;
          mem_we   = 1'b1;
          if (new_fill == (FillW + 1)'(target)) begin
            pop_mode_d = 1'b0;
            any_d      = 1'b0;
            row_d      = '0;
            state_d    = S_MIN;
          end else begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end
        end
      end

      // lowest ray number among used sets
      S_MIN: begin
        if (row_valid && (!any_q || row_key < best_key_q)) begin
          any_d      = 1'b1;
          best_row_d = row_q;
          best_key_d = row_key;
        end
        if (row_last) begin
          row_d   = (row_valid && (!any_q || row_key < best_key_q)) ? row_q : best_row_q;
          state_d = S_MIN_CHK;
        end else begin
          row_d = row_q + 1'b1;
        end
      end

      S_MIN_CHK: begin
        slot_d = '0;
        if (pop_mode_q) begin
          if (!any_q || row_fill != target) begin
            emit        = 1'b1;
            emit_status = ST_EMPTY;
            state_d     = S_IDLE;
          end else begin
            state_d = S_POP_RD;
          end
        end else if (!any_q || row_fill == target) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end else begin
          disc_d  = disc_sum[DiscardW] ? '1 : disc_sum[DiscardW-1:0];
          state_d = S_REL_RD;
        end
      end

      // discard an incomplete set into the free queue
      S_REL_RD: begin
        if (row_mask[slot_q]) begin
          mem_re  = 1'b1;
          state_d = S_REL_WR;
        end else if (slot_last) begin
          tab_release = 1'b1;
          any_d       = 1'b0;
          row_d       = '0;
          state_d     = S_MIN;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end

      S_REL_WR: begin
        fifo_ctrl.push = 1'b1;
        if (slot_last) begin
          tab_release = 1'b1;
          any_d       = 1'b0;
          row_d       = '0;
          state_d     = S_MIN;
        end else begin
          slot_d  = slot_q + 1'b1;
          state_d = S_REL_RD;
        end
      end

      // hand out a complete set slot by slot
      S_POP_RD: begin
        if (row_mask[slot_q]) begin
          mem_re  = 1'b1;
          state_d = S_POP_OUT;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end

      S_POP_OUT: begin
        emit        = 1'b1;
        emit_handle = mem_rd_q;
        emit_prt    = 2'(slot_q >> 2);
        emit_chan   = 3'(slot_q[1:0]) + 3'd1;
        emit_last   = (((row_mask >> slot_q) >> 1) == '0);
        if (emit_last) begin
          tab_release = 1'b1;
          state_d     = S_IDLE;
        end else begin
          slot_d  = slot_q + 1'b1;
          state_d = S_POP_RD;
        end
      end

      S_FREE_OUT: begin
        emit        = 1'b1;
        emit_handle = fifo_data;
        state_d     = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      disc_q      <= '0;
      res_valid_o <= 1'b0;
      for (int i = 0; i < MAX_SETS; i++) begin
        set_valid_q[i] <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      disc_q      <= disc_d;
      res_valid_o <= emit;
      if (tab_open) begin
        set_valid_q[row_q] <= 1'b1;
      end else if (tab_release) begin
        set_valid_q[row_q] <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pop_mode_q <= pop_mode_d;
    row_q      <= row_d;
    slot_q     <= slot_d;
    in_slot_q  <= in_slot_d;
    key_q      <= key_d;
    handle_q   <= handle_d;
    hit_q      <= hit_d;
    free_q     <= free_d;
    any_q      <= any_d;
    hit_row_q  <= hit_row_d;
    free_row_q <= free_row_d;
    best_row_q <= best_row_d;
    best_key_q <= best_key_d;
    if (tab_add) begin
      set_fill_q[row_q] <= new_fill[FillW-1:0];
      if (tab_open) begin
        set_key_q[row_q]  <= key_q;
        set_mask_q[row_q] <= Slots'(1) << in_slot_q;
      end else begin
        set_mask_q[row_q] <= row_mask | (Slots'(1) << in_slot_q);
      end
    end
    if (mem_we) begin
      slot_mem[{row_q, in_slot_q}] <= handle_q;
    end
    if (mem_re) begin
      mem_rd_q <= slot_mem[mem_rd_addr];
    end
    status_o        <= emit_status;
    handle_out_o    <= emit_handle;
    prt_out_o       <= emit_prt;
    channel_out_o   <= emit_chan;
    discard_total_o <= emit_disc;
    handles_lost_o  <= fifo_stat.overflow;
    last_o          <= emit_last;
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
